@@ hdl/ifp_pkg.sv @@
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared types and constants for the interleaved framebuffer plotter.
// ----------------------------------------------------------------------------
package ifp_pkg;

    localparam int ADDR_W    = 14;
    localparam int DATA_W    = 8;
    localparam int X_W       = 8;
    localparam int Y_W       = 7;
    localparam int COLOUR_W  = 2;
    localparam int ORIGIN_W  = 3;
    localparam int COL_W     = 9;
    localparam int ROW_W     = 8;
    localparam int OFS_W     = 15;
    localparam int PLOT_ROWS = 100;

    localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = 3'd5;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_BLOCK = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MERGE,
        ST_EVEN
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

@@ hdl/ifp_channels.sv @@
// ----------------------------------------------------------------------------
// ifp channels
// Valid/ready channels for plot commands and framebuffer write transactions.
// ----------------------------------------------------------------------------
interface ifp_plot_if;
    import ifp_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [X_W-1:0]      x;
    logic [Y_W-1:0]      y;
    logic [COLOUR_W-1:0] colour;

    modport source (output valid, mode, x, y, colour, input ready);
    modport sink   (input valid, mode, x, y, colour, output ready);
endinterface

interface ifp_wr_if;
    import ifp_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic              last;

    modport source (output valid, write_address, write_data, last, input ready);
    modport sink   (input valid, write_address, write_data, last, output ready);
endinterface

@@ hdl/interleaved_framebuffer_plotter.sv @@
// ----------------------------------------------------------------------------
// interleaved_framebuffer_plotter
// The first write transaction is loaded in ST_MERGE, after ST_IDLE and ST_READ.
// Each plotted pixel passes ST_MERGE (even field write) and ST_EVEN (odd field
// write); a fully clipped plot goes from ST_READ back to ST_IDLE. The walker holds
// while the write channel stalls, and plot.ready is high only in ST_IDLE.
// Reset: x_origin returns to 5; the store is cleared one byte per cycle
// (FIELD_BYTES bytes, 8192 by default) with plot.ready held low meanwhile.
// ----------------------------------------------------------------------------
module interleaved_framebuffer_plotter #(
    parameter int ROW_BYTES   = 80,
    parameter int FIELD_BYTES = 8192,
    parameter int BLOCK_SIZE  = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ifp_pkg::ORIGIN_W-1:0]  cfg_wdata,
    ifp_plot_if.sink                      plot,
    ifp_wr_if.source                      wr
);
    import ifp_pkg::*;

    logic [ORIGIN_W-1:0] x_origin_reg;
    mem_req_t            mem_req;
    logic [DATA_W-1:0]   mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= ORIGIN_RESET;
        end
        else if (cfg_we)
        begin
            x_origin_reg <= cfg_wdata;
        end
    end

    ifp_seq #(
        .ROW_BYTES   (ROW_BYTES),
        .FIELD_BYTES (FIELD_BYTES),
        .BLOCK_SIZE  (BLOCK_SIZE)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .x_origin  (x_origin_reg),
        .plot      (plot),
        .wr        (wr),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    ifp_store #(
        .FIELD_BYTES (FIELD_BYTES)
    ) u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

@@ hdl/ifp_store.sv @@
// ----------------------------------------------------------------------------
// ifp_store
// Single copy of the mirrored field: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ifp_store #(
    parameter int FIELD_BYTES = 8192
) (
    input  logic                         clk,
    input  ifp_pkg::mem_req_t            req,
    output logic [ifp_pkg::DATA_W-1:0]   rdata
);
    import ifp_pkg::*;

    localparam int AW = $clog2(FIELD_BYTES);

    logic [DATA_W-1:0] mem [FIELD_BYTES];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ifp_seq.sv @@
// ----------------------------------------------------------------------------
// ifp_seq
// Pixel walker: clears the store, steps through block pixels, does the
// nibble read-modify-write and emits the even and odd field writes.
// ----------------------------------------------------------------------------
module ifp_seq #(
    parameter int ROW_BYTES   = 80,
    parameter int FIELD_BYTES = 8192,
    parameter int BLOCK_SIZE  = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ifp_pkg::ORIGIN_W-1:0]   x_origin,
    ifp_plot_if.sink                       plot,
    ifp_wr_if.source                       wr,
    output ifp_pkg::mem_req_t              mem_req,
    input  logic [ifp_pkg::DATA_W-1:0]     mem_rdata
);
    import ifp_pkg::*;

    localparam int AW   = $clog2(FIELD_BYTES);
    localparam int SZ_W = $clog2(BLOCK_SIZE + 1);

    localparam logic [COL_W-1:0] COL_LIM   = COL_W'(2 * ROW_BYTES);
    localparam logic [ROW_W-1:0] ROW_LIM   = ROW_W'(PLOT_ROWS);
    localparam logic [OFS_W-1:0] ROW_STEP  = OFS_W'(ROW_BYTES);
    localparam logic [OFS_W-1:0] FB_OFS    = OFS_W'(FIELD_BYTES);
    localparam logic [SZ_W-1:0]  BLK       = SZ_W'(BLOCK_SIZE);
    localparam logic [AW-1:0]    CLR_LAST  = AW'(FIELD_BYTES - 1);

    seq_state_t state_reg, state_next;

    logic [AW-1:0]       clr_reg;
    logic                out_valid_reg;
    logic                out_odd_reg;
    logic                out_last_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [DATA_W-1:0]   out_data_reg;

    logic [COL_W-1:0]    col0_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [OFS_W-1:0]    row_base_reg;
    logic [SZ_W-1:0]     dx_reg;
    logic [SZ_W-1:0]     dy_reg;
    logic [SZ_W-1:0]     size_reg;
    logic [COLOUR_W-1:0] colour_reg;

    logic [OFS_W-1:0]    cur_ofs;
    logic [OFS_W-1:0]    odd_ofs;
    logic                cur_ok;
    logic [SZ_W:0]       dx_inc;
    logic [SZ_W:0]       dy_inc;
    logic [COL_W-1:0]    col_inc;
    logic [ROW_W-1:0]    row_inc;
    logic                go_right;
    logic                go_down;
    logic [COL_W-1:0]    nxt_col;
    logic [OFS_W-1:0]    nxt_row_base;
    logic [OFS_W-1:0]    nxt_ofs;
    logic                nxt_ok;
    logic [3:0]          nib;
    logic [DATA_W-1:0]   merged;
    logic                slot_free;
    logic                accept;
    logic                load_even;
    logic                load_odd;
    logic                advance;

    assign cur_ofs = row_base_reg + OFS_W'(col_reg >> 1);
    assign odd_ofs = cur_ofs + FB_OFS;
    assign cur_ok  = (col_reg < COL_LIM) && (row_reg < ROW_LIM) && (cur_ofs < FB_OFS);

    assign dx_inc  = {1'b0, dx_reg} + (SZ_W+1)'(1);
    assign dy_inc  = {1'b0, dy_reg} + (SZ_W+1)'(1);
    assign col_inc = col_reg + COL_W'(1);
    assign row_inc = row_reg + ROW_W'(1);

    assign go_right     = (dx_inc < {1'b0, size_reg}) && (col_inc < COL_LIM);
    assign go_down      = (dy_inc < {1'b0, size_reg}) && (row_inc < ROW_LIM);
    assign nxt_col      = go_right ? col_inc : col0_reg;
    assign nxt_row_base = go_right ? row_base_reg : row_base_reg + ROW_STEP;
    assign nxt_ofs      = nxt_row_base + OFS_W'(nxt_col >> 1);
    assign nxt_ok       = (go_right || go_down) && (nxt_ofs < FB_OFS);

    assign nib    = {colour_reg, colour_reg};
    assign merged = col_reg[0] ? {mem_rdata[7:4], nib} : {nib, mem_rdata[3:0]};

    assign slot_free = !out_valid_reg || wr.ready;
    assign accept    = plot.valid && plot.ready;

    always_comb
    begin
        state_next = state_reg;
        mem_req    = '0;
        plot.ready = 1'b0;
        load_even  = 1'b0;
        load_odd   = 1'b0;
        advance    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(clr_reg);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                plot.ready = 1'b1;
                if (plot.valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cur_ok)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = cur_ofs[ADDR_W-1:0];
                    state_next    = ST_MERGE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MERGE:
            begin
                if (slot_free)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = cur_ofs[ADDR_W-1:0];
                    mem_req.wdata = merged;
                    load_even     = 1'b1;
                    state_next    = ST_EVEN;
                end
            end
            ST_EVEN:
            begin
                if (slot_free)
                begin
                    load_odd = 1'b1;
                    if (nxt_ok)
                    begin
                        advance       = 1'b1;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = nxt_ofs[ADDR_W-1:0];
                        state_next    = ST_MERGE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_odd_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (load_even)
            begin
                out_valid_reg <= 1'b1;
                out_odd_reg   <= 1'b0;
                out_last_reg  <= 1'b0;
            end
            else if (load_odd)
            begin
                out_valid_reg <= 1'b1;
                out_odd_reg   <= 1'b1;
                out_last_reg  <= !nxt_ok;
            end
            else if (wr.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_even)
        begin
            out_addr_reg <= cur_ofs[ADDR_W-1:0];
            out_data_reg <= merged;
        end
        else if (load_odd)
        begin
            out_addr_reg <= odd_ofs[ADDR_W-1:0];
        end

        if (accept)
        begin
            col0_reg     <= COL_W'(plot.x) + COL_W'(x_origin);
            col_reg      <= COL_W'(plot.x) + COL_W'(x_origin);
            row_reg      <= ROW_W'(plot.y);
            row_base_reg <= OFS_W'(plot.y) * ROW_STEP;
            dx_reg       <= '0;
            dy_reg       <= '0;
            size_reg     <= (plot.mode == MODE_BLOCK) ? BLK : SZ_W'(1);
            colour_reg   <= plot.colour;
        end
        else if (advance)
        begin
            col_reg      <= nxt_col;
            row_base_reg <= nxt_row_base;
            if (go_right)
            begin
                dx_reg <= dx_inc[SZ_W-1:0];
            end
            else
            begin
                dx_reg  <= '0;
                dy_reg  <= dy_inc[SZ_W-1:0];
                row_reg <= row_inc;
            end
        end
    end

    assign wr.valid         = out_valid_reg;
    assign wr.write_address = out_addr_reg;
    assign wr.write_data    = out_data_reg;
    assign wr.last          = out_last_reg;

    // store write and read never share a cycle, so no forwarding path is needed
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("store read and write in the same cycle");

    a_odd_follows_even: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.valid && wr.ready && !out_odd_reg) |=>
            (wr.valid && out_odd_reg && $stable(out_data_reg)))
        else $error("odd field write does not follow even field write");

    a_even_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_odd_reg) |-> !out_last_reg)
        else $error("even field write marked last");

    a_idle_no_even: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!out_valid_reg || out_odd_reg))
        else $error("idle with an even field write pending");

    a_merge_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE && $past(state_reg) != ST_MERGE) |-> $past(mem_req.re))
        else $error("merge entered without a store read");

endmodule

@@ sim/tb_interleaved_framebuffer_plotter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interleaved_framebuffer_plotter
// Sends single-pixel and 3x3 block plot commands under several x_origin
// settings. A shadow framebuffer predicts each even/odd field write
// transaction. Both channels see random idle bursts.
// ----------------------------------------------------------------------------
module tb_interleaved_framebuffer_plotter;
    import ifp_pkg::*;

    localparam int ROW_BYTES     = 80;
    localparam int FIELD_BYTES   = 8192;
    localparam int FB_AW         = $clog2(FIELD_BYTES);
    localparam int BLOCK_SIZE    = 3;
    localparam int PLOT_COLS     = 2 * ROW_BYTES;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic              last;
    } fb_write_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [ORIGIN_W-1:0] cfg_wdata;
    logic                sink_ready = 1'b0;

    ifp_plot_if plot_if ();
    ifp_wr_if   wr_if ();

    assign wr_if.ready = sink_ready;

    interleaved_framebuffer_plotter #(
        .ROW_BYTES   (ROW_BYTES),
        .FIELD_BYTES (FIELD_BYTES),
        .BLOCK_SIZE  (BLOCK_SIZE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .plot      (plot_if),
        .wr        (wr_if)
    );

    logic [DATA_W-1:0]   shadow_fb [FIELD_BYTES];
    logic [ORIGIN_W-1:0] shadow_origin;
    fb_write_t           expected_writes [$];
    fb_write_t           want_write;
    fb_write_t           got_write;
    bit                  idling_on;
    int unsigned         cycle_count;
    int unsigned         plots_sent;
    int unsigned         writes_checked;
    int unsigned         mismatches;
    int unsigned         origin_writes;
    int unsigned         stall_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("interleaved_framebuffer_plotter test failed");
        $finish;
    end

    // write-side backpressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            sink_ready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end
        else
            sink_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && wr_if.valid && wr_if.ready)
        begin
            got_write.address = wr_if.write_address;
            got_write.data    = wr_if.write_data;
            got_write.last    = wr_if.last;
            if (expected_writes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected write addr %0d data %02h last %0b",
                             $time, got_write.address, got_write.data, got_write.last);
            end
            else
            begin
                want_write = expected_writes.pop_front();
                writes_checked++;
                if (got_write.address !== want_write.address ||
                    got_write.data !== want_write.data ||
                    got_write.last !== want_write.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: write mismatch exp addr %0d data %02h last %0b",
                                 $time, want_write.address, want_write.data,
                                 want_write.last);
                        $display("    got addr %0d data %02h last %0b",
                                 got_write.address, got_write.data, got_write.last);
                    end
                end
            end
        end
    end

    function automatic void predict_plot(logic mode, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                         logic [COLOUR_W-1:0] colour);
        int               blk_size;
        int               first;
        int               col;
        int               row;
        int               ofs;
        logic [FB_AW-1:0] idx;
        fb_write_t        item;
        blk_size = (mode == MODE_BLOCK) ? BLOCK_SIZE : 1;
        first    = expected_writes.size();
        for (int dy = 0; dy < blk_size; dy++)
        begin
            for (int dx = 0; dx < blk_size; dx++)
            begin
                col = int'(x) + int'(shadow_origin) + dx;
                row = int'(y) + dy;
                ofs = row * ROW_BYTES + col / 2;
                if (col < PLOT_COLS && row < PLOT_ROWS && ofs < FIELD_BYTES)
                begin
                    idx = ofs[FB_AW-1:0];
                    if (col % 2 == 1)
                        shadow_fb[idx] = {shadow_fb[idx][7:4], colour, colour};
                    else
                        shadow_fb[idx] = {colour, colour, shadow_fb[idx][3:0]};
                    item.data    = shadow_fb[idx];
                    item.last    = 1'b0;
                    item.address = ADDR_W'(ofs);
                    expected_writes.push_back(item);
                    item.address = ADDR_W'(ofs + FIELD_BYTES);
                    expected_writes.push_back(item);
                end
            end
        end
        if (expected_writes.size() > first)
            expected_writes[expected_writes.size() - 1].last = 1'b1;
    endfunction

    task automatic send_plot(logic mode, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                             logic [COLOUR_W-1:0] colour);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            plot_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        plot_if.valid  <= 1'b1;
        plot_if.mode   <= mode;
        plot_if.x      <= x;
        plot_if.y      <= y;
        plot_if.colour <= colour;
        do
            @(posedge clk);
        while (!plot_if.ready);
        predict_plot(mode, x, y, colour);
        plots_sent++;
    endtask

    task automatic drain_writes();
        plot_if.valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_origin(logic [ORIGIN_W-1:0] value);
        drain_writes();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        shadow_origin = value;
        origin_writes++;
    endtask

    // reset origin of 5: column 5 is odd, column 6 even
    task automatic test_single_pixels();
        send_plot(MODE_PIXEL, 8'd0, 7'd0, 2'd3);
        send_plot(MODE_PIXEL, 8'd1, 7'd0, 2'd2);
        send_plot(MODE_PIXEL, 8'd0, 7'd0, 2'd0);
        send_plot(MODE_PIXEL, 8'd154, 7'd99, 2'd1);
        send_plot(MODE_PIXEL, 8'd153, 7'd50, 2'd2);
        send_plot(MODE_PIXEL, 8'd155, 7'd0, 2'd3);
        send_plot(MODE_PIXEL, 8'd10, 7'd100, 2'd3);
        send_plot(MODE_PIXEL, 8'd255, 7'd127, 2'd3);
    endtask

    task automatic test_blocks();
        send_plot(MODE_BLOCK, 8'd0, 7'd0, 2'd1);
        send_plot(MODE_BLOCK, 8'd1, 7'd1, 2'd2);
        send_plot(MODE_BLOCK, 8'd153, 7'd97, 2'd3);
        send_plot(MODE_BLOCK, 8'd154, 7'd98, 2'd1);
        send_plot(MODE_BLOCK, 8'd200, 7'd10, 2'd3);
        send_plot(MODE_BLOCK, 8'd20, 7'd126, 2'd3);
        send_plot(MODE_BLOCK, 8'd0, 7'd0, 2'd0);
    endtask

    task automatic test_origin_extremes();
        write_origin(3'd0);
        send_plot(MODE_PIXEL, 8'd0, 7'd0, 2'd3);
        send_plot(MODE_BLOCK, 8'd158, 7'd0, 2'd2);
        write_origin(3'd7);
        send_plot(MODE_PIXEL, 8'd152, 7'd5, 2'd1);
        send_plot(MODE_PIXEL, 8'd153, 7'd5, 2'd1);
        send_plot(MODE_BLOCK, 8'd0, 7'd99, 2'd2);
    endtask

    task automatic test_random_plots(int count, bit with_idling);
        logic                mode;
        logic [X_W-1:0]      x;
        logic [Y_W-1:0]      y;
        logic [COLOUR_W-1:0] colour;
        for (int i = 0; i < count; i++)
        begin
            if (i % 20 == 0)
                idling_on = with_idling && ($urandom_range(0, 3) != 0);
            mode   = 1'($urandom_range(0, 1));
            colour = COLOUR_W'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 8)
            begin
                x = X_W'($urandom_range(0, PLOT_COLS - 1));
                y = Y_W'($urandom_range(0, PLOT_ROWS - 1));
            end
            else
            begin
                x = X_W'($urandom_range(0, 255));
                y = Y_W'($urandom_range(0, 127));
            end
            send_plot(mode, x, y, colour);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        plot_if.valid  = 1'b0;
        plot_if.mode   = MODE_PIXEL;
        plot_if.x      = '0;
        plot_if.y      = '0;
        plot_if.colour = '0;
        foreach (shadow_fb[i])
            shadow_fb[i] = '0;
        shadow_origin = ORIGIN_RESET;
        repeat (5) @(posedge clk);
        rst_n     <= 1'b1;
        idling_on = 1'b1;

        test_single_pixels();
        test_blocks();
        test_origin_extremes();
        for (int phase = 0; phase < 4; phase++)
        begin
            idling_on = 1'b1;
            if (phase == 0)
                write_origin(3'd0);
            else if (phase == 1)
                write_origin(3'd7);
            else
                write_origin(ORIGIN_W'($urandom_range(0, 7)));
            test_random_plots(95, 1'b1);
        end
        idling_on = 1'b0;
        write_origin(ORIGIN_W'($urandom_range(0, 7)));
        test_random_plots(40, 1'b0);
        drain_writes();

        $display("Covered %0d pixel and 3x3 block plots with clipped edges, %0d origin writes",
                 plots_sent, origin_writes);
        $display("Checked %0d field write transactions, %0d mismatches", writes_checked, mismatches);
        if (mismatches == 0 && expected_writes.size() == 0)
            $display("interleaved_framebuffer_plotter test passed");
        else
            $display("interleaved_framebuffer_plotter test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ifp_pkg.sv
hdl/ifp_channels.sv
hdl/ifp_store.sv
hdl/ifp_seq.sv
hdl/interleaved_framebuffer_plotter.sv
sim/tb_interleaved_framebuffer_plotter.sv
